// ===== src/t0ape_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the T=0 APDU transfer engine.
// No dependencies.
package t0ape_pkg;

   localparam int CommandDepthDefault = 512;
   localparam logic [8:0] CapacityReset = 9'd258;

   typedef enum logic [1:0] {
      MODE_HOST = 2'd0,
      MODE_CARD = 2'd1,
      MODE_SLOT = 2'd2,
      MODE_LINK_ERR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_TO_CARD = 2'd0,
      KIND_TO_HOST = 2'd1,
      KIND_DONE = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_NO_BUFFER = 3'd2;
   localparam logic [2:0] ST_PROTOCOL = 3'd3;
   localparam logic [2:0] ST_COMM = 3'd4;

   localparam logic [7:0] BYTE_NULL = 8'h60;
   localparam logic [3:0] SW1_HI_A = 4'h6;
   localparam logic [3:0] SW1_HI_B = 4'h9;
   localparam logic [8:0] LE_ZERO_VALUE = 9'h100;
   localparam logic [2:0] HEADER_LEN = 3'd5;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] status;
      logic [8:0] response_length;
      logic       run_end;
   } rsp_type;

   // One front-to-back entry: up to two results produced by one item.
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } pair_type;

endpackage

// ===== src/t0ape_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interface carrying a packed payload.
// No dependencies.
interface t0ape_if #(
   parameter int Width = 8
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/t0ape_front.sv =====
`timescale 1ns / 1ps
// Front end: command store, APDU classification and T=0 protocol sequencer.
// Depends on t0ape_pkg.
module t0ape_front
   import t0ape_pkg::*;
#(
   parameter int CommandDepth = CommandDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [8:0] csr_wdata,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_item,
   output logic       pair_valid,
   output pair_type   pair_data,
   input  logic       space_ok
);
   localparam int AW = $clog2(CommandDepth);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_PROC, PH_SEND_ALL, PH_SEND_ONE, PH_RECV, PH_SW2
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [8:0] cap_ff;
   logic [9:0] len_ff, len_in;
   logic [2:0] hdr_ff, hdr_in;
   logic [8:0] sidx_ff, sidx_in;
   logic [7:0] scnt_ff, scnt_in;
   logic [8:0] exp_ff, exp_in;
   logic [8:0] rcv_ff, rcv_in;
   logic [8:0] bulk_ff, bulk_in;
   // Header bytes mirrored in flops.
   logic [7:0] hb_ff [5];
   logic [7:0] mem [CommandDepth];
   logic [7:0] rd_ff;

   // Data bytes are read ahead: rd_ff holds store[5 + sidx_ff] at all times
   // during sending since sidx only moves on send and the read refreshes.
   logic       take;
   logic [9:0] rd_idx;
   logic       rd_in_range;
   logic       rd_ok_ff;

   assign in_ready = space_ok;
   assign take = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (take && in_item.mode == MODE_HOST && phase_ff == PH_IDLE &&
          {1'b0, len_ff} < 11'(CommandDepth)) begin
         mem[len_ff[AW-1:0]] <= in_item.data_byte;
      end
      rd_ff <= mem[rd_idx[AW-1:0]];
      rd_ok_ff <= rd_in_range;
   end

   always_ff @(posedge clock) begin
      if (take && in_item.mode == MODE_HOST && phase_ff == PH_IDLE) begin
         if (len_ff < 10'd5) hb_ff[len_ff[2:0]] <= in_item.data_byte;
      end
   end

   // Next read address follows next send index.
   assign rd_idx = 10'd5 + {1'b0, sidx_in};
   assign rd_in_range = {1'b0, rd_idx} < 11'(CommandDepth);

   rsp_type r0, r1;
   logic n_two, n_any;

   function automatic rsp_type mk(input kind_type k, input logic [7:0] b,
                                  input logic [2:0] s, input logic [8:0] l);
      rsp_type r;
      r.kind = k;
      r.out_byte = b;
      r.status = s;
      r.response_length = l;
      r.run_end = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [7:0] b, ack, inv;
      logic [9:0] len1;
      logic [8:0] nc, ne, freesp, rcv1;
      logic       fin;
      logic [2:0] fst;
      logic [7:0] lastb;
      phase_in = phase_ff;
      len_in = len_ff;
      hdr_in = hdr_ff;
      sidx_in = sidx_ff;
      scnt_in = scnt_ff;
      exp_in = exp_ff;
      rcv_in = rcv_ff;
      bulk_in = bulk_ff;
      r0 = mk(KIND_NONE, 8'd0, ST_OK, 9'd0);
      r1 = r0;
      n_any = 1'b0;
      n_two = 1'b0;
      fin = 1'b0;
      fst = ST_OK;
      b = in_item.data_byte;
      ack = hb_ff[1];
      inv = ~ack;
      len1 = 10'd0;
      nc = 9'd0;
      ne = 9'd0;
      lastb = 8'd0;
      rcv1 = rcv_ff + 9'd1;
      freesp = (exp_ff > rcv_ff) ? exp_ff - rcv_ff : 9'd0;
      if (take) begin
         if (in_item.mode == MODE_LINK_ERR) begin
            if (phase_ff != PH_IDLE) begin fin = 1'b1; fst = ST_COMM; end
         end else begin
            case (phase_ff)
               PH_IDLE: if (in_item.mode == MODE_HOST) begin
                  len1 = (len_ff < 10'd1023) ? len_ff + 10'd1 : len_ff;
                  len_in = len1;
                  if (in_item.last_byte) begin
                     rcv_in = 9'd0;
                     // Byte 4 and last byte may be this very item.
                     lastb = b;
                     nc = {1'b0, (len_ff == 10'd4) ? b : hb_ff[4]};
                     if (len1 < 10'd4) begin
                        fin = 1'b1; fst = ST_INVALID;
                     end else begin
                        if (len1 == 10'd5) begin
                           ne = (nc[7:0] == 8'd0) ? LE_ZERO_VALUE : nc;
                           nc = 9'd0;
                        end else if (len1 > 10'd5) begin
                           if (len1 == {1'b0, nc} + 10'd5) ne = 9'd0;
                           else if (len1 == {1'b0, nc} + 10'd6)
                              ne = (lastb == 8'd0) ? LE_ZERO_VALUE : {1'b0, lastb};
                           else begin fin = 1'b1; fst = ST_INVALID; end
                        end else nc = 9'd0;
                        if (!fin && {1'b0, cap_ff} < {1'b0, ne} + 10'd2) begin
                           fin = 1'b1; fst = ST_NO_BUFFER;
                        end
                        if (!fin) begin
                           exp_in = ne + 9'd2;
                           scnt_in = nc[7:0];
                           sidx_in = 9'd0;
                           hdr_in = 3'd0;
                           bulk_in = 9'd0;
                           phase_in = PH_HEADER;
                        end
                     end
                     if (fin) rcv_in = 9'd0;
                  end
               end
               PH_HEADER: if (in_item.mode == MODE_SLOT) begin
                  n_any = 1'b1;
                  r0 = mk(KIND_TO_CARD,
                          (hdr_ff < 3'd4) ? hb_ff[hdr_ff] :
                          ((len_ff >= 10'd5) ? hb_ff[4] : 8'd0), ST_OK, 9'd0);
                  hdr_in = hdr_ff + 3'd1;
                  if (hdr_in >= HEADER_LEN) phase_in = PH_PROC;
               end
               PH_PROC: if (in_item.mode == MODE_CARD && b != BYTE_NULL) begin
                  if (b[7:4] == SW1_HI_A || b[7:4] == SW1_HI_B) begin
                     if (rcv_ff >= exp_ff) begin fin = 1'b1; fst = ST_PROTOCOL; end
                     else begin
                        n_any = 1'b1;
                        r0 = mk(KIND_TO_HOST, b, ST_OK, 9'd0);
                        rcv_in = rcv1;
                        if (rcv1 >= exp_ff) begin fin = 1'b1; fst = ST_PROTOCOL; end
                        else phase_in = PH_SW2;
                     end
                  end else if (b == ack || b == inv) begin
                     if ({1'b0, scnt_ff} > sidx_ff)
                        phase_in = (b == ack) ? PH_SEND_ALL : PH_SEND_ONE;
                     else if (freesp <= 9'd2) begin fin = 1'b1; fst = ST_PROTOCOL; end
                     else begin
                        bulk_in = (b == ack) ? freesp - 9'd2 : 9'd1;
                        phase_in = PH_RECV;
                     end
                  end
               end
               PH_SEND_ALL, PH_SEND_ONE: if (in_item.mode == MODE_SLOT) begin
                  n_any = 1'b1;
                  r0 = mk(KIND_TO_CARD, rd_ok_ff ? rd_ff : 8'd0, ST_OK, 9'd0);
                  sidx_in = sidx_ff + 9'd1;
                  if (phase_ff == PH_SEND_ONE || sidx_in >= {1'b0, scnt_ff})
                     phase_in = PH_PROC;
               end
               PH_RECV: if (in_item.mode == MODE_CARD) begin
                  n_any = 1'b1;
                  r0 = mk(KIND_TO_HOST, b, ST_OK, 9'd0);
                  rcv_in = rcv1;
                  bulk_in = (bulk_ff > 9'd0) ? bulk_ff - 9'd1 : 9'd0;
                  if (bulk_in == 9'd0) phase_in = PH_PROC;
               end
               PH_SW2: if (in_item.mode == MODE_CARD) begin
                  n_any = 1'b1;
                  r0 = mk(KIND_TO_HOST, b, ST_OK, 9'd0);
                  rcv_in = rcv1;
                  fin = 1'b1; fst = ST_OK;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         if (fin) begin
            phase_in = PH_IDLE;
            len_in = 10'd0;
            if (n_any) begin
               n_two = 1'b1;
               r1 = mk(KIND_DONE, 8'd0, fst, rcv_in);
            end else begin
               n_any = 1'b1;
               r0 = mk(KIND_DONE, 8'd0, fst, rcv_in);
            end
         end
      end
      // Flag the last result of the transaction.
      if (n_two) r1.run_end = 1'b1;
      else r0.run_end = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cap_ff <= CapacityReset;
         len_ff <= '0;
         hdr_ff <= '0;
         sidx_ff <= '0;
         scnt_ff <= '0;
         exp_ff <= '0;
         rcv_ff <= '0;
         bulk_ff <= '0;
         pair_valid <= 1'b0;
      end else begin
         if (csr_write) cap_ff <= csr_wdata;
         phase_ff <= phase_in;
         len_ff <= len_in;
         hdr_ff <= hdr_in;
         sidx_ff <= sidx_in;
         scnt_ff <= scnt_in;
         exp_ff <= exp_in;
         rcv_ff <= rcv_in;
         bulk_ff <= bulk_in;
         pair_valid <= n_any;
      end
   end

   always_ff @(posedge clock) begin
      pair_data.first <= r0;
      pair_data.second <= r1;
      pair_data.two <= n_two;
   end
endmodule

// ===== src/t0ape_back.sv =====
`timescale 1ns / 1ps
// Back end: queue of result pairs and serializer onto the response channel.
// Depends on t0ape_pkg.
module t0ape_back
   import t0ape_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     pair_valid,
   input  pair_type pair_data,
   output logic     space_ok,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_item
);
   localparam int Depth = 4;
   pair_type q_ff [Depth];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       half_ff;
   logic       pop, pop_item;

   // Leave room for the pair held in the front register and the one accepted
   // now, with one slot to spare.
   assign space_ok = cnt_ff <= 3'(Depth - 3);
   assign out_valid = cnt_ff != 3'd0;
   assign out_item = half_ff ? q_ff[rp_ff].second : q_ff[rp_ff].first;
   assign pop_item = out_valid && out_ready;
   assign pop = pop_item && (half_ff || !q_ff[rp_ff].two);
   assign cnt_in = cnt_ff + {2'b0, pair_valid} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (pair_valid) q_ff[wp_ff] <= pair_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         if (pair_valid) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_in;
         if (pop) half_ff <= 1'b0;
         else if (pop_item) half_ff <= 1'b1;
      end
   end
endmodule

// ===== src/t0_apdu_transfer_engine.sv =====
`timescale 1ns / 1ps
// Top level of the T=0 APDU transfer engine.
// Depends on t0ape_pkg, t0ape_if, t0ape_front and t0ape_back.
//
// The engine takes one transaction per clock on req while req is ready: host
// command bytes, card bytes, transmitter-free slots and link errors. The front
// end keeps the command in a COMMAND_DEPTH-byte store, classifies the APDU and
// runs the T=0 procedure-byte sequencer combinationally, registering its
// results; each transaction yields zero, one or two results, which pass
// through a four-entry queue to the back end. The back end drives one result
// per clock on rsp while rsp is ready. req stays ready while the queue has
// room for the results still in flight, so with rsp always ready the
// sustained rate is one transaction per clock, less only where transactions
// yield two results (completions that follow a delivered byte). The store
// needs no clearing pass after reset.
module t0_apdu_transfer_engine
   import t0ape_pkg::*;
#(
   parameter int COMMAND_DEPTH = CommandDepthDefault
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   csr_write,
   input  logic [8:0] csr_wdata,
   t0ape_if.sink  req,
   t0ape_if.source rsp
);
   logic     pair_valid;
   pair_type pair_data;
   logic     space_ok;
   rsp_type  rsp_item;

   t0ape_front #(.CommandDepth(COMMAND_DEPTH)) u_front (
      .clock, .reset, .csr_write, .csr_wdata,
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req_type'(req.payload)),
      .pair_valid, .pair_data, .space_ok
   );

   t0ape_back u_back (
      .clock, .reset, .pair_valid, .pair_data, .space_ok,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(rsp_item)
   );

   assign rsp.payload = rsp_item;
endmodule
